// ----- hdl/ptws_pkg.sv -----
// Shared types, widths and constants for the periodic waveform scaler.
package ptws_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int IDX_W  = 8;
  localparam int TIME_W = 32;
  localparam int VAL_W  = 24;
  localparam int CNT_W  = 9;
  localparam int SEG_W  = 8;
  localparam int DRV_W  = 32;

  localparam int IN_W   = IDX_W + TIME_W + VAL_W + TIME_W;
  localparam int OUT_W  = VAL_W + DRV_W + SEG_W;

  // quotient bits kept by the divider; anything larger saturates the scale anyway
  localparam int QBITS  = 25;
  localparam int QCNT_W = $clog2(QBITS);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_ENABLED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BC_PARAMETER  = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic signed [VAL_W-1:0] ONE_Q16   = 24'sd65536;
  localparam logic signed [VAL_W-1:0] SCALE_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] SCALE_MIN = 24'sh800000;

  typedef struct packed {
    logic [CNT_W-1:0] point_count;
    logic             scale_enabled;
    logic [VAL_W-1:0] bc_parameter;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic start;
    logic idle_scale;
    logic check;
    logic wrap;
    logic fetch_a;
    logic setup;
    logic mul;
    logic div_init;
    logic div_step;
    logic finish;
    logic drive;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic wrap;
    logic div_skip;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/ptws_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ptws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ptws_ctrl.sv -----
// Sequencer for load and tick items of the waveform scaler.
module ptws_ctrl import ptws_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_action,
  input  logic     scale_enabled,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHK   = 11'b000_0000_0010,
    S_WRAP  = 11'b000_0000_0100,
    S_FETCH = 11'b000_0000_1000,
    S_SETUP = 11'b000_0001_0000,
    S_MUL   = 11'b000_0010_0000,
    S_DIVI  = 11'b000_0100_0000,
    S_DIV   = 11'b000_1000_0000,
    S_FIN   = 11'b001_0000_0000,
    S_DRV   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_LOAD) begin
            cmd.load = 1'b1;
          end else if (scale_enabled) begin
            cmd.start  = 1'b1;
            state_next = S_CHK;
          end else begin
            cmd.idle_scale = 1'b1;
            state_next     = S_DRV;
          end
        end
      end
      S_CHK: begin
        cmd.check  = 1'b1;
        state_next = stat.wrap ? S_WRAP : S_FETCH;
      end
      S_WRAP: begin
        cmd.wrap   = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch_a = 1'b1;
        state_next  = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = stat.div_skip ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_DRV;
      end
      S_DRV: begin
        cmd.drive  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ptws_dpath.sv -----
// Datapath: point table, time tracking, interpolation divider, drive multiply, output stage.
module ptws_dpath import ptws_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  cfg_t              cfg,
  input  logic [IDX_W-1:0]  point_index,
  input  logic [TIME_W-1:0] point_time,
  input  logic [VAL_W-1:0]  point_value,
  input  logic [TIME_W-1:0] time_step,
  output logic [OUT_W-1:0]  out_data,
  output logic              out_valid,
  input  logic              out_ready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
  localparam int MW = TIME_W + VAL_W;
  localparam int NW = VAL_W + TIME_W;   // product magnitude width
  localparam int HW = NW - QBITS;       // dividend bits above the quotient window

  // table memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [MW-1:0] ram_rdata;
  logic [TIME_W-1:0]       rd_t;
  logic signed [VAL_W-1:0] rd_v;

  // timing state
  logic [TIME_W-1:0] elapsed;
  logic [AW-1:0]     position;
  logic [AW-1:0]     pw;
  logic [AW-1:0]     lenm1;
  logic [AW-1:0]     nxt;
  logic [AW:0]       pw_inc;
  logic              wrap_c;
  logic [TIME_W:0]   step_sum;

  // interpolation
  logic [TIME_W-1:0]       t0;
  logic signed [VAL_W-1:0] v0;
  logic [TIME_W-1:0]       den_mag;
  logic [TIME_W-1:0]       dt_mag;
  logic [VAL_W-1:0]        dv_mag;
  logic                    neg;
  logic                    zero_den;
  logic [NW-1:0]           num_mag;
  logic [TIME_W-1:0]       rem;
  logic [QBITS-1:0]        quo;
  logic [QCNT_W-1:0]       cnt;
  logic                    ovf;
  logic                    hi_ge;
  logic [TIME_W:0]         rem_sh;
  logic                    step_ge;
  logic signed [VAL_W:0]   dv;
  logic                    den_neg;
  logic                    dt_neg;
  logic [QBITS:0]          qmag;
  logic signed [QBITS+1:0] sq;
  logic signed [QBITS+2:0] fin_sum;

  logic signed [VAL_W-1:0]   scale;
  logic signed [2*VAL_W-1:0] prod;

  ptws_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({point_value, point_time}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_t = ram_rdata[TIME_W-1:0];
  assign rd_v = signed'(ram_rdata[MW-1:TIME_W]);

  assign ram_we    = cmd.load && (IW'(point_index) < IW'(TABLE_DEPTH));
  assign ram_waddr = AW'(point_index);

  // last valid point: count of zero acts as one, large counts clamp to the depth
  always_comb begin
    if (cfg.point_count == '0) begin
      lenm1 = '0;
    end else if (CW'(cfg.point_count) > CW'(TABLE_DEPTH)) begin
      lenm1 = AW'(TABLE_DEPTH - 1);
    end else begin
      lenm1 = AW'(CW'(cfg.point_count) - CW'(1));
    end
  end

  assign step_sum = {1'b0, elapsed} + {1'b0, time_step};
  assign pw_inc   = (rd_t < elapsed) ? {1'b0, position} + (AW + 1)'(1) : {1'b0, position};
  assign wrap_c   = pw_inc > {1'b0, lenm1};
  assign nxt      = (pw < lenm1) ? pw + AW'(1) : '0;

  always_comb begin
    ram_raddr = position;
    if (cmd.check) begin
      ram_raddr = wrap_c ? lenm1 : pw_inc[AW-1:0];
    end else if (cmd.wrap) begin
      ram_raddr = '0;
    end else if (cmd.fetch_a) begin
      ram_raddr = nxt;
    end
  end

  // segment deltas as sign and magnitude
  assign den_neg = rd_t < t0;
  assign dt_neg  = elapsed < t0;
  assign dv      = (VAL_W + 1)'(rd_v) - (VAL_W + 1)'(v0);

  assign hi_ge   = {1'b0, num_mag[NW-1:QBITS]} >= (HW + 1)'(den_mag);
  assign rem_sh  = {rem, quo[QBITS-1]};
  assign step_ge = rem_sh >= {1'b0, den_mag};

  assign qmag    = ovf ? {1'b1, {QBITS{1'b0}}} : {1'b0, quo};
  assign sq      = neg ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
  assign fin_sum = (QBITS + 3)'(v0) + (QBITS + 3)'(sq);

  assign stat.wrap     = wrap_c;
  assign stat.div_skip = zero_den || hi_ge;
  assign stat.div_last = (cnt == QCNT_W'(QBITS - 1));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      position <= '0;
      scale    <= ONE_Q16;
    end else begin
      if (cmd.start) begin
        elapsed <= step_sum[TIME_W] ? '1 : step_sum[TIME_W-1:0];
      end
      if (cmd.check) begin
        pw <= wrap_c ? '0 : pw_inc[AW-1:0];
      end
      if (cmd.wrap) begin
        // rd_t holds the period here
        elapsed <= (elapsed > rd_t) ? elapsed - rd_t : '0;
      end
      if (cmd.fetch_a) begin
        t0       <= rd_t;
        v0       <= rd_v;
        position <= pw;
      end
      if (cmd.setup) begin
        den_mag  <= den_neg ? t0 - rd_t : rd_t - t0;
        dt_mag   <= dt_neg ? t0 - elapsed : elapsed - t0;
        dv_mag   <= dv[VAL_W] ? VAL_W'(-dv) : dv[VAL_W-1:0];
        neg      <= den_neg ^ dt_neg ^ dv[VAL_W];
        zero_den <= (rd_t == t0);
      end
      if (cmd.mul) begin
        num_mag <= NW'(dv_mag) * NW'(dt_mag);
      end
      if (cmd.div_init) begin
        ovf <= hi_ge && !zero_den;
        rem <= TIME_W'(num_mag[NW-1:QBITS]);
        quo <= zero_den ? '0 : num_mag[QBITS-1:0];
        cnt <= '0;
      end
      if (cmd.div_step) begin
        rem <= step_ge ? TIME_W'(rem_sh - {1'b0, den_mag}) : rem_sh[TIME_W-1:0];
        quo <= {quo[QBITS-2:0], step_ge};
        cnt <= cnt + QCNT_W'(1);
      end
      if (cmd.finish) begin
        if (fin_sum > (QBITS + 3)'(SCALE_MAX)) begin
          scale <= SCALE_MAX;
        end else if (fin_sum < (QBITS + 3)'(SCALE_MIN)) begin
          scale <= SCALE_MIN;
        end else begin
          scale <= fin_sum[VAL_W-1:0];
        end
      end
      if (cmd.idle_scale) begin
        scale <= ONE_Q16;
      end
    end
  end

  // product magnitude is at most 2^46, so the floor shift always fits 32 bits
  always_ff @(posedge clk) begin
    if (cmd.drive) begin
      prod <= (2 * VAL_W)'(scale) * (2 * VAL_W)'(signed'(cfg.bc_parameter));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {SEG_W'(position), prod[DRV_W+15:16], scale};
    end
  end

endmodule

// ----- hdl/periodic_table_waveform_scaler_core.sv -----
// Top level of the periodic piecewise-linear waveform scaler.
// Load items write one (time, value) point into the table; they give no result.
// A tick with the waveform disabled gives scale 1.0 and goes straight to the drive step.
// A tick with the waveform enabled checks the position, wraps it to point zero when
// needed, fetches the segment, sets up and multiplies the deltas, and runs the
// 25-step restoring divider that forms the interpolation quotient one bit per cycle;
// the divider is skipped when the quotient is trivial (zero-length segment or a
// quotient that saturates the scale). The finished result sits in an output
// register, so loads are taken while it waits. The table is a simple dual-port RAM
// (one write port, one registered read port) and needs no clearing pass.
module periodic_table_waveform_scaler_core import ptws_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_index, point_time, point_value, time_step
  input  logic [IN_W-1:0]      s_axis_tdata,
  // action
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // scale_value, drive_value, segment_index
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point_count   <= CNT_W'(1);
      cfg.scale_enabled <= 1'b0;
      cfg.bc_parameter  <= ONE_Q16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POINT_COUNT:   cfg.point_count   <= cfg_data[CNT_W-1:0];
        REG_SCALE_ENABLED: cfg.scale_enabled <= cfg_data[0];
        REG_BC_PARAMETER:  cfg.bc_parameter  <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  ptws_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_action     (s_axis_tuser[0]),
    .scale_enabled (cfg.scale_enabled),
    .stat          (stat),
    .cmd           (cmd)
  );

  ptws_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg         (cfg),
    .point_index (s_axis_tdata[IDX_W-1:0]),
    .point_time  (s_axis_tdata[IDX_W+TIME_W-1:IDX_W]),
    .point_value (s_axis_tdata[IDX_W+TIME_W+VAL_W-1:IDX_W+TIME_W]),
    .time_step   (s_axis_tdata[IN_W-1:IDX_W+TIME_W+VAL_W]),
    .out_data    (m_axis_tdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready)
  );

endmodule

// ----- hdl/ptws_checker.sv -----
// Port-level checks for the waveform scaler, bound to the top level.
module ptws_checker import ptws_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [0:0]       s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a tick transfer starts work, so the input side closes next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_TICK) |=> !s_axis_tready)
    else $error("input still open after a tick");

  // a load keeps the input side open for the next item
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_LOAD) |=> s_axis_tready)
    else $error("input closed after a load");

  // a new result only comes out of a tick in progress
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a tick in progress");

endmodule

bind periodic_table_waveform_scaler_core ptws_checker u_ptws_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
